// ----- rtl/brp_pkg.sv -----
// ----------------------------------------------------------------------------
// Baud reload pick package
// Shared widths, constants and a helper function for the baud reload selector.
// ----------------------------------------------------------------------------
package brp_pkg;

  // Field widths.
  localparam int CLK_W    = 24;
  localparam int BAUD_W   = 20;
  localparam int RELOAD_W = 10;
  localparam int ACT_W    = 19;

  // Divider geometry: 20-bit dividend and quotient, 22-bit divisor.
  localparam int DIV_W = 20;
  localparam int REM_W = 22;

  // Quotient wide enough to hold the generator span itself.
  localparam int Q_W = 11;

  localparam logic [Q_W-1:0]   GEN_SPAN   = 11'd1024;
  localparam logic [Q_W-1:0]   TMR_SPAN   = 11'd256;
  localparam logic [ACT_W-1:0] ACT_MAX    = 19'h7FFFF;
  localparam logic [CLK_W-1:0] CLK_RESET  = 24'd16000000;

  // UART modes that use baud generation.
  localparam logic [1:0] MODE_1 = 2'd1;
  localparam logic [1:0] MODE_3 = 2'd3;

  // Dividend after the power-of-two part of the divisor is shifted out.
  // Generator: clk * 2^(1+s) / 64. Timer: clk * 2^(1+s) / 128, then / 3.
  function automatic logic [DIV_W-1:0] dividend(input logic [CLK_W-1:0] clk_hz,
                                                input logic gen, input logic s);
    logic [DIV_W-1:0] res;
    if (gen && s) begin
      res = clk_hz[CLK_W-1:4];
    end else if (gen || s) begin
      res = {1'b0, clk_hz[CLK_W-1:5]};
    end else begin
      res = {2'b0, clk_hz[CLK_W-1:6]};
    end
    return res;
  endfunction

endpackage

// ----- rtl/brp_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, a new division may enter every cycle that en is high.
// ----------------------------------------------------------------------------
module brp_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [brp_pkg::DIV_W-1:0]   num_i,
  input  logic [brp_pkg::REM_W-1:0]   den_i,
  output logic [brp_pkg::DIV_W-1:0]   quo_o
);

  logic [brp_pkg::DIV_W-1:0] num_r   [brp_pkg::DIV_W];
  logic [brp_pkg::DIV_W-1:0] quo_r   [brp_pkg::DIV_W];
  logic [brp_pkg::REM_W-1:0] rem_r   [brp_pkg::DIV_W];
  logic [brp_pkg::REM_W-1:0] den_r   [brp_pkg::DIV_W];
  logic [brp_pkg::DIV_W-1:0] num_nxt [brp_pkg::DIV_W];
  logic [brp_pkg::DIV_W-1:0] quo_nxt [brp_pkg::DIV_W];
  logic [brp_pkg::REM_W-1:0] rem_nxt [brp_pkg::DIV_W];
  logic [brp_pkg::REM_W-1:0] den_nxt [brp_pkg::DIV_W];

  // Each stage shifts in one dividend bit and tries a subtract.
  always_comb begin
    logic [brp_pkg::DIV_W-1:0] num_in;
    logic [brp_pkg::DIV_W-1:0] quo_in;
    logic [brp_pkg::REM_W-1:0] rem_in;
    logic [brp_pkg::REM_W-1:0] den_in;
    logic [brp_pkg::REM_W:0]   trial;
    logic [brp_pkg::REM_W:0]   diff;
    for (int k = 0; k < brp_pkg::DIV_W; k++) begin
      if (k == 0) begin
        num_in = num_i;
        quo_in = '0;
        rem_in = '0;
        den_in = den_i;
      end else begin
        num_in = num_r[k-1];
        quo_in = quo_r[k-1];
        rem_in = rem_r[k-1];
        den_in = den_r[k-1];
      end
      trial = {rem_in, num_in[brp_pkg::DIV_W-1]};
      diff  = trial - {1'b0, den_in};
      if (trial >= {1'b0, den_in}) begin
        rem_nxt[k] = diff[brp_pkg::REM_W-1:0];
        quo_nxt[k] = {quo_in[brp_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[brp_pkg::REM_W-1:0];
        quo_nxt[k] = {quo_in[brp_pkg::DIV_W-2:0], 1'b0};
      end
      num_nxt[k] = {num_in[brp_pkg::DIV_W-2:0], 1'b0};
      den_nxt[k] = den_in;
    end
  end

  // Stage registers advance together with the rest of the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < brp_pkg::DIV_W; k++) begin
        num_r[k] <= num_nxt[k];
        quo_r[k] <= quo_nxt[k];
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_nxt[k];
      end
    end
  end

  assign quo_o = quo_r[brp_pkg::DIV_W-1];

endmodule

// ----- rtl/uart_baud_reload_selector.sv -----
// ----------------------------------------------------------------------------
// UART baud reload selector
// Picks the reload value and doubling bit that best approach a baud rate.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake          | Payload
// in       | input     | in_valid/in_stall  | desired_baud, uart_mode, generator
// out      | output    | out_valid/out_stall| applies, reload, smod, actual, error
// cfg      | input     | cfg_wr_en          | clock frequency in Hz
//
// One word is accepted per cycle while in_stall is low; the pipeline is two 20-stage
// dividers (quotient, then actual rate) plus four stages of control logic.
// Reset clears valid bits and loads a 16 MHz clock frequency.
// A stalled output word freezes the entire pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module uart_baud_reload_selector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [brp_pkg::CLK_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [brp_pkg::BAUD_W-1:0]    in_desired_baud,
  input  logic [1:0]                    in_uart_mode,
  input  logic                          in_use_baud_generator,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_applies,
  output logic [brp_pkg::RELOAD_W-1:0]  out_reload_value,
  output logic                          out_smod,
  output logic [brp_pkg::ACT_W-1:0]     out_actual_baud,
  output logic [brp_pkg::BAUD_W-1:0]    out_baud_error,
  output logic                          out_out_of_range
);

  typedef struct packed {
    logic                       applies;
    logic                       gen;
    logic                       zero;
    logic [brp_pkg::BAUD_W-1:0] baud;
    logic [brp_pkg::Q_W-1:0]    q0;
    logic [brp_pkg::Q_W-1:0]    q1;
    logic                       f0;
    logic                       f1;
  } side_t;

  logic                          en;
  logic [brp_pkg::CLK_W-1:0]     clk_hz_r;

  logic                          v0_r;
  side_t                         side0_r;
  logic [brp_pkg::REM_W-1:0]     den0_r;

  logic                          v1_r    [brp_pkg::DIV_W];
  side_t                         side1_r [brp_pkg::DIV_W];
  logic [brp_pkg::DIV_W-1:0]     quo1_0, quo1_1;

  logic                          vq_r;
  side_t                         sideq_r;
  side_t                         sideq_nxt;
  logic [brp_pkg::REM_W-1:0]     den2_0, den2_1;

  logic                          v2_r    [brp_pkg::DIV_W];
  side_t                         side2_r [brp_pkg::DIV_W];
  logic [brp_pkg::DIV_W-1:0]     quo2_0, quo2_1;

  logic                          va_r;
  side_t                         sidea_r;
  logic [brp_pkg::ACT_W-1:0]     act0_r, act1_r, act0_nxt, act1_nxt;
  logic [brp_pkg::BAUD_W-1:0]    err0_r, err1_r, err0_nxt, err1_nxt;

  logic                          out_valid_r;
  logic                          applies_r, smod_r, oor_r;
  logic [brp_pkg::RELOAD_W-1:0]  reload_r;
  logic [brp_pkg::ACT_W-1:0]     actual_r;
  logic [brp_pkg::BAUD_W-1:0]    error_r;

  // Low reload bits; the difference never exceeds 1023.
  function automatic logic [brp_pkg::RELOAD_W-1:0] RELOAD_SEL(
    input logic [brp_pkg::Q_W-1:0] v);
    return v[brp_pkg::RELOAD_W-1:0];
  endfunction

  // The pipeline moves whenever the output register can take a word.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Clock frequency register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= brp_pkg::CLK_RESET;
    end else if (cfg_wr_en) begin
      clk_hz_r <= cfg_wr_data;
    end
  end

  // Input stage: decode mode and form the first divisor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0_r.applies <= (in_uart_mode == brp_pkg::MODE_1) ||
                         (in_uart_mode == brp_pkg::MODE_3);
      side0_r.gen     <= in_use_baud_generator;
      side0_r.zero    <= (in_desired_baud == '0);
      side0_r.baud    <= in_desired_baud;
      side0_r.q0      <= '0;
      side0_r.q1      <= '0;
      side0_r.f0      <= 1'b0;
      side0_r.f1      <= 1'b0;
      if (in_use_baud_generator) begin
        den0_r <= {2'b0, in_desired_baud};
      end else begin
        den0_r <= {2'b0, in_desired_baud} + {1'b0, in_desired_baud, 1'b0};
      end
    end
  end

  // Rounded quotient for both doubling settings.
  brp_div u_div_q0 (
    .clk   (clk),
    .en    (en),
    .num_i (brp_pkg::dividend(clk_hz_r, side0_r.gen, 1'b0)),
    .den_i (den0_r),
    .quo_o (quo1_0)
  );

  brp_div u_div_q1 (
    .clk   (clk),
    .en    (en),
    .num_i (brp_pkg::dividend(clk_hz_r, side0_r.gen, 1'b1)),
    .den_i (den0_r),
    .quo_o (quo1_1)
  );

  // Sideband travels alongside the first divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < brp_pkg::DIV_W; k++) begin
        v1_r[k] <= 1'b0;
      end
    end else if (en) begin
      v1_r[0] <= v0_r;
      for (int k = 1; k < brp_pkg::DIV_W; k++) begin
        v1_r[k] <= v1_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r[0] <= side0_r;
      for (int k = 1; k < brp_pkg::DIV_W; k++) begin
        side1_r[k] <= side1_r[k-1];
      end
    end
  end

  // Round half up and clamp each quotient into the reload span.
  always_comb begin
    side_t                   sd;
    logic [brp_pkg::DIV_W:0] r0, r1;
    logic [brp_pkg::Q_W-1:0] span;
    sd   = side1_r[brp_pkg::DIV_W-1];
    span = sd.gen ? brp_pkg::GEN_SPAN : brp_pkg::TMR_SPAN;
    r0   = ({1'b0, quo1_0} + 21'd1) >> 1;
    r1   = ({1'b0, quo1_1} + 21'd1) >> 1;
    sideq_nxt = sd;
    if (sd.zero) begin
      sideq_nxt.q0 = span;
      sideq_nxt.f0 = 1'b1;
    end else if (r0 == '0) begin
      sideq_nxt.q0 = 11'd1;
      sideq_nxt.f0 = 1'b1;
    end else if (r0 > {10'b0, span}) begin
      sideq_nxt.q0 = span;
      sideq_nxt.f0 = 1'b1;
    end else begin
      sideq_nxt.q0 = r0[brp_pkg::Q_W-1:0];
      sideq_nxt.f0 = 1'b0;
    end
    if (sd.zero) begin
      sideq_nxt.q1 = span;
      sideq_nxt.f1 = 1'b1;
    end else if (r1 == '0) begin
      sideq_nxt.q1 = 11'd1;
      sideq_nxt.f1 = 1'b1;
    end else if (r1 > {10'b0, span}) begin
      sideq_nxt.q1 = span;
      sideq_nxt.f1 = 1'b1;
    end else begin
      sideq_nxt.q1 = r1[brp_pkg::Q_W-1:0];
      sideq_nxt.f1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else if (en) begin
      vq_r <= v1_r[brp_pkg::DIV_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sideq_r <= sideq_nxt;
    end
  end

  // Divisor for the actual rate: q, or 3q for timer 1.
  always_comb begin
    if (sideq_r.gen) begin
      den2_0 = {11'b0, sideq_r.q0};
      den2_1 = {11'b0, sideq_r.q1};
    end else begin
      den2_0 = {11'b0, sideq_r.q0} + {10'b0, sideq_r.q0, 1'b0};
      den2_1 = {11'b0, sideq_r.q1} + {10'b0, sideq_r.q1, 1'b0};
    end
  end

  brp_div u_div_a0 (
    .clk   (clk),
    .en    (en),
    .num_i (brp_pkg::dividend(clk_hz_r, sideq_r.gen, 1'b0)),
    .den_i (den2_0),
    .quo_o (quo2_0)
  );

  brp_div u_div_a1 (
    .clk   (clk),
    .en    (en),
    .num_i (brp_pkg::dividend(clk_hz_r, sideq_r.gen, 1'b1)),
    .den_i (den2_1),
    .quo_o (quo2_1)
  );

  // Sideband travels alongside the second divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < brp_pkg::DIV_W; k++) begin
        v2_r[k] <= 1'b0;
      end
    end else if (en) begin
      v2_r[0] <= vq_r;
      for (int k = 1; k < brp_pkg::DIV_W; k++) begin
        v2_r[k] <= v2_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r[0] <= sideq_r;
      for (int k = 1; k < brp_pkg::DIV_W; k++) begin
        side2_r[k] <= side2_r[k-1];
      end
    end
  end

  // Round the actual rates, saturate, and take the error against the request.
  always_comb begin
    logic [brp_pkg::DIV_W:0]    a0, a1;
    logic [brp_pkg::BAUD_W-1:0] b;
    b  = side2_r[brp_pkg::DIV_W-1].baud;
    a0 = ({1'b0, quo2_0} + 21'd1) >> 1;
    a1 = ({1'b0, quo2_1} + 21'd1) >> 1;
    act0_nxt = (a0 > {2'b0, brp_pkg::ACT_MAX}) ? brp_pkg::ACT_MAX
                                               : a0[brp_pkg::ACT_W-1:0];
    act1_nxt = (a1 > {2'b0, brp_pkg::ACT_MAX}) ? brp_pkg::ACT_MAX
                                               : a1[brp_pkg::ACT_W-1:0];
    err0_nxt = ({1'b0, act0_nxt} > b) ? ({1'b0, act0_nxt} - b) : (b - {1'b0, act0_nxt});
    err1_nxt = ({1'b0, act1_nxt} > b) ? ({1'b0, act1_nxt} - b) : (b - {1'b0, act1_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= v2_r[brp_pkg::DIV_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sidea_r <= side2_r[brp_pkg::DIV_W-1];
      act0_r  <= act0_nxt;
      act1_r  <= act1_nxt;
      err0_r  <= err0_nxt;
      err1_r  <= err1_nxt;
    end
  end

  // Output register: pick the smaller error, ties go to doubling on; other modes give zeros.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [brp_pkg::Q_W-1:0] span;
    span = sidea_r.gen ? brp_pkg::GEN_SPAN : brp_pkg::TMR_SPAN;
    if (en) begin
      if (!sidea_r.applies) begin
        applies_r <= 1'b0;
        reload_r  <= '0;
        smod_r    <= 1'b0;
        actual_r  <= '0;
        error_r   <= '0;
        oor_r     <= 1'b0;
      end else if (err0_r < err1_r) begin
        applies_r <= 1'b1;
        reload_r  <= RELOAD_SEL(span - sidea_r.q0);
        smod_r    <= 1'b0;
        actual_r  <= act0_r;
        error_r   <= err0_r;
        oor_r     <= sidea_r.f0;
      end else begin
        applies_r <= 1'b1;
        reload_r  <= RELOAD_SEL(span - sidea_r.q1);
        smod_r    <= 1'b1;
        actual_r  <= act1_r;
        error_r   <= err1_r;
        oor_r     <= sidea_r.f1;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_applies      = applies_r;
  assign out_reload_value = reload_r;
  assign out_smod         = smod_r;
  assign out_actual_baud  = actual_r;
  assign out_baud_error   = error_r;
  assign out_out_of_range = oor_r;

endmodule

// ----- tb/uart_baud_reload_selector_tb.sv -----
// ----------------------------------------------------------------------------
// UART baud reload selector testbench
// Drives baud requests across clock settings, predicts each result word from
// an independent model of the reload and doubling-bit choice, and checks the
// results in order under random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module uart_baud_reload_selector_tb;

  localparam int LATENCY = 44;
  localparam int WATCHDOG_LIMIT = 20000;

  // Expected result word.
  typedef struct packed {
    logic                         applies;
    logic [brp_pkg::RELOAD_W-1:0] reload_value;
    logic                         smod;
    logic [brp_pkg::ACT_W-1:0]    actual_baud;
    logic [brp_pkg::BAUD_W-1:0]   baud_error;
    logic                         out_of_range;
  } baud_pick_t;

  typedef struct {
    logic [brp_pkg::RELOAD_W-1:0] reload;
    logic [brp_pkg::ACT_W-1:0]    actual;
    logic [brp_pkg::BAUD_W-1:0]   err;
    logic                         flag;
  } baud_cand_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic [brp_pkg::CLK_W-1:0]    cfg_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [brp_pkg::BAUD_W-1:0]   in_desired_baud = '0;
  logic [1:0]                   in_uart_mode = '0;
  logic                         in_use_baud_generator = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_applies;
  logic [brp_pkg::RELOAD_W-1:0] out_reload_value;
  logic                         out_smod;
  logic [brp_pkg::ACT_W-1:0]    out_actual_baud;
  logic [brp_pkg::BAUD_W-1:0]   out_baud_error;
  logic                         out_out_of_range;

  logic [brp_pkg::CLK_W-1:0] model_clk_hz = brp_pkg::CLK_RESET;
  baud_pick_t       pick_queue[$];
  int               fail_count = 0;
  int               idle_cycles = 0;
  bit               idling_on = 1'b1;

  uart_baud_reload_selector i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_desired_baud(in_desired_baud),
    .in_uart_mode(in_uart_mode), .in_use_baud_generator(in_use_baud_generator),
    .out_valid(out_valid), .out_stall(out_stall), .out_applies(out_applies),
    .out_reload_value(out_reload_value), .out_smod(out_smod),
    .out_actual_baud(out_actual_baud), .out_baud_error(out_baud_error),
    .out_out_of_range(out_out_of_range)
  );

  always #5 clk = ~clk;

  // One candidate for a given doubling bit, with clamping of the quotient.
  function automatic baud_cand_t eval_smod(logic [brp_pkg::BAUD_W-1:0] baud, bit s,
                                           bit gen);
    longint unsigned num, q, act, span, dv;
    baud_cand_t c;
    num  = longint'(model_clk_hz) * (s ? 4 : 2);
    span = gen ? 1024 : 256;
    dv   = gen ? 64 : 384;
    c.flag = 1'b0;
    if (baud == 0) q = span + 1;
    else q = (num / (dv * baud) + 1) / 2;
    if (q == 0) begin
      q = 1;
      c.flag = 1'b1;
    end else if (q > span) begin
      q = span;
      c.flag = 1'b1;
    end
    c.reload = brp_pkg::RELOAD_W'(span - q);
    act = (num / (dv * q) + 1) / 2;
    if (act > brp_pkg::ACT_MAX) act = brp_pkg::ACT_MAX;
    c.actual = brp_pkg::ACT_W'(act);
    c.err = (act > baud) ? brp_pkg::BAUD_W'(act - baud) : brp_pkg::BAUD_W'(baud - act);
    return c;
  endfunction

  // Best reload and doubling bit for one request; a tie goes to doubling.
  function automatic baud_pick_t pick_reload(logic [brp_pkg::BAUD_W-1:0] baud,
                                             logic [1:0] mode, bit gen);
    baud_pick_t r;
    baud_cand_t c0, c1, w;
    r = '0;
    if (mode == brp_pkg::MODE_1 || mode == brp_pkg::MODE_3) begin
      c0 = eval_smod(baud, 1'b0, gen);
      c1 = eval_smod(baud, 1'b1, gen);
      r.smod = !(c0.err < c1.err);
      w = r.smod ? c1 : c0;
      r.applies = 1'b1;
      r.reload_value = w.reload;
      r.actual_baud = w.actual;
      r.baud_error = w.err;
      r.out_of_range = w.flag;
    end
    return r;
  endfunction

  // Send one request word, with random idling beforehand.
  task automatic send_request(logic [brp_pkg::BAUD_W-1:0] baud, logic [1:0] mode,
                              bit gen);
    while (idling_on && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_desired_baud <= baud;
    in_uart_mode <= mode;
    in_use_baud_generator <= gen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pick_queue.push_back(pick_reload(baud, mode, gen));
    @(negedge clk);
  endtask

  // Wait until every expected word has arrived, then let the pipeline drain.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pick_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_clock(logic [brp_pkg::CLK_W-1:0] hz);
    drain_and_settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= hz;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_clk_hz = hz;
  endtask

  // Random stall on the result side.
  always @(negedge clk) begin
    out_stall <= idling_on && ($urandom_range(99) < 27);
  end

  // Result checker.
  always @(posedge clk) begin
    baud_pick_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pick_queue.size() == 0) begin
        $error("result word with no expectation");
        fail_count++;
      end else begin
        e = pick_queue.pop_front();
        if (out_applies !== e.applies) begin
          $error("applies exp %0d got %0d", e.applies, out_applies); fail_count++;
        end
        if (out_reload_value !== e.reload_value) begin
          $error("reload_value exp %0d got %0d", e.reload_value, out_reload_value);
          fail_count++;
        end
        if (out_smod !== e.smod) begin
          $error("smod exp %0d got %0d", e.smod, out_smod); fail_count++;
        end
        if (out_actual_baud !== e.actual_baud) begin
          $error("actual_baud exp %0d got %0d", e.actual_baud, out_actual_baud);
          fail_count++;
        end
        if (out_baud_error !== e.baud_error) begin
          $error("baud_error exp %0d got %0d", e.baud_error, out_baud_error);
          fail_count++;
        end
        if (out_out_of_range !== e.out_of_range) begin
          $error("out_of_range exp %0d got %0d", e.out_of_range, out_out_of_range);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Extremes of every field and both modes that bypass baud generation.
  task automatic test_directed();
    logic [1:0] m;
    for (int k = 0; k < 4; k++) begin
      m = 2'(k);
      send_request(20'd9600, m, 1'b0);
      send_request(20'd9600, m, 1'b1);
    end
    send_request(20'd0, brp_pkg::MODE_1, 1'b0);
    send_request(20'd0, brp_pkg::MODE_3, 1'b1);
    send_request(20'd1, brp_pkg::MODE_1, 1'b0);
    send_request(20'd1, brp_pkg::MODE_3, 1'b1);
    send_request(20'hFFFFF, brp_pkg::MODE_1, 1'b0);
    send_request(20'hFFFFF, brp_pkg::MODE_3, 1'b1);
    send_request(20'd1000000, brp_pkg::MODE_1, 1'b1);
    send_request(20'd115200, brp_pkg::MODE_3, 1'b0);
    send_request(20'd41667, brp_pkg::MODE_1, 1'b0);
    send_request(20'd250000, brp_pkg::MODE_1, 1'b1);
  endtask

  // Random requests, mostly in modes that generate a baud rate.
  task automatic test_random(int count);
    logic [brp_pkg::BAUD_W-1:0] b;
    logic [1:0] m;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(3))
        0: b = brp_pkg::BAUD_W'($urandom);
        1: b = brp_pkg::BAUD_W'($urandom_range(20));
        default: b = brp_pkg::BAUD_W'($urandom_range(1000000, 1));
      endcase
      m = ($urandom_range(9) < 8) ? ($urandom_range(1) ? brp_pkg::MODE_3 : brp_pkg::MODE_1)
                                  : 2'($urandom);
      send_request(b, m, 1'($urandom_range(1)));
    end
  endtask

  task automatic test_no_idling(int count);
    idling_on = 1'b0;
    test_random(count);
    idling_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(80);
    write_clock(24'd1);
    test_directed();
    write_clock(24'hFFFFFF);
    test_random(60);
    write_clock(24'd11059200);
    test_random(80);
    test_no_idling(80);
    write_clock(brp_pkg::CLK_W'($urandom_range(16000000, 1)));
    test_random(96);
    write_clock(24'd16000000);
    test_directed();
    drain_and_settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/brp_pkg.sv
rtl/brp_div.sv
rtl/uart_baud_reload_selector.sv
tb/uart_baud_reload_selector_tb.sv
